// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/stt_pkg.sv
// Types and constants of the subtree count toggle tree unit.
package stt_pkg;

  localparam int NODE_W = 10;
  localparam int CNT_W  = 10;

  typedef enum logic [1:0] {
    OP_LINK   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_TOGGLE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // One entry of the node memory: mark bit and subtree count.
  typedef struct packed {
    logic             mark;
    logic [CNT_W-1:0] count;
  } node_word_t;

endpackage

// File: design/stt_in_if.sv
// Input channel: one operation per transaction.
interface stt_in_if;
  logic                      valid;
  logic                      ready;
  stt_pkg::op_t              op;
  logic [stt_pkg::NODE_W-1:0] node;
  logic [stt_pkg::NODE_W-1:0] parent;

  modport source(output valid, output op, output node, output parent, input ready);
  modport sink(input valid, input op, input node, input parent, output ready);
endinterface

// File: design/stt_out_if.sv
// Result channel: one query count per transaction.
interface stt_out_if;
  logic                      valid;
  logic                      ready;
  logic [stt_pkg::CNT_W-1:0] count;

  modport source(output valid, output count, input ready);
  modport sink(input valid, input count, output ready);
endinterface

// File: design/stt_ram.sv
// Generic simple dual-port RAM with registered read.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/subtree_count_toggle_tree_unit.sv
// Top level of the subtree count toggle tree unit.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------
//   in_if   | in        | valid/ready         | op, node, parent
//   out_if  | out       | valid/ready         | count (query only)
//   apb     | in/out    | psel/penable/pready | node_count at offset 0
//
// Steps: link writes the parent memory on acceptance; query reads the node
//   memory and waits on the output register; toggle reads both memories,
//   writes the flipped mark and count, then reads and writes each ancestor.
// Build clears the count of every entry, read then write, then for each
//   node 1..last walks its ancestor chain, a read and a write per level.
// Reset: after rst_n the parent memory is cleared one entry a cycle,
//   all DEPTH entries, with in_if.ready low; config writes are taken as ever.
// Stalls: a query result waits in the output register; the next item is
//   accepted meanwhile, and a further query holds until that register frees.
`include "assert_macros.svh"

module subtree_count_toggle_tree_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  stt_in_if.sink      in_if,
  stt_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import stt_pkg::*;

  // Node fields are 10 bits wide, so no entry above 1023 is ever reached.
  localparam int DEPTH = (MAX_NODES < (1 << NODE_W)) ? MAX_NODES : (1 << NODE_W);
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLR_RD,
    S_CLR_WR,
    S_W_CHK,
    S_W_UP,
    S_T_WR,
    S_Q_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [NODE_W-1:0] i_r, i_nxt;
  logic [NODE_W-1:0] last_r, last_nxt;
  logic [NODE_W-1:0] t_r, t_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [SW-1:0]     steps_r, steps_nxt;
  logic              dec_r, dec_nxt;
  logic              build_r, build_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [NODE_W-1:0] node_count_r, node_count_nxt;

  // Parent memory port signals.
  logic              par_we, par_re;
  logic [AW-1:0]     par_waddr, par_raddr;
  logic [NODE_W-1:0] par_wdata, par_rdata;

  // Node memory (mark and count) port signals.
  logic              nw_we, nw_re;
  logic [AW-1:0]     nw_waddr, nw_raddr;
  node_word_t        nw_wdata, nw_rdata;

  logic              in_acc;
  logic              in_node_ok, node_ok, walk_go;
  logic [CNT_W-1:0]  step_val, first_step;

  stt_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .re    (par_re),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  stt_ram #(.WIDTH($bits(node_word_t)), .DEPTH(DEPTH)) u_node_ram (
    .clk   (clk),
    .we    (nw_we),
    .waddr (nw_waddr),
    .wdata (nw_wdata),
    .re    (nw_re),
    .raddr (nw_raddr),
    .rdata (nw_rdata)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.count = out_count_r;

  // APB: single register, always ready; address bit 2 low selects it, high reads zero.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - NODE_W){1'b0}}, node_count_r};

  assign in_node_ok = (32'(in_if.node) < MAX_NODES);
  assign node_ok    = (32'(node_r) < MAX_NODES);
  // A walk stops at node zero, at a parent out of range, or after MAX_NODES updates.
  assign walk_go    = (t_r != '0) && (32'(t_r) < MAX_NODES) && (32'(steps_r) < MAX_NODES);
  assign step_val   = dec_r ? {CNT_W{1'b1}} : CNT_W'(1);
  assign first_step = nw_rdata.mark ? {CNT_W{1'b1}} : CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    i_nxt          = i_r;
    last_nxt       = last_r;
    t_nxt          = t_r;
    node_nxt       = node_r;
    steps_nxt      = steps_r;
    dec_nxt        = dec_r;
    build_nxt      = build_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_count_nxt  = out_count_r;
    node_count_nxt = node_count_r;

    par_we    = 1'b0;
    par_waddr = '0;
    par_wdata = '0;
    par_re    = 1'b0;
    par_raddr = '0;
    nw_we     = 1'b0;
    nw_waddr  = '0;
    nw_wdata  = '0;
    nw_re     = 1'b0;
    nw_raddr  = '0;

    if (psel && penable && pwrite && pready && !paddr[2]) begin
      node_count_nxt = pwdata[NODE_W-1:0];
    end

    case (state_r)
      S_INIT: begin
        // Clear the parent memory after reset.
        par_we    = 1'b1;
        par_waddr = idx_r;
        if (idx_r == AW'(DEPTH - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          node_nxt = in_if.node;
          case (in_if.op)
            OP_LINK: begin
              if (in_node_ok) begin
                par_we    = 1'b1;
                par_waddr = in_if.node[AW-1:0];
                par_wdata = in_if.parent;
              end
            end
            OP_BUILD: begin
              if (32'(node_count_r) > MAX_NODES - 1) begin
                last_nxt = NODE_W'(MAX_NODES - 1);
              end else begin
                last_nxt = node_count_r;
              end
              idx_nxt   = '0;
              build_nxt = 1'b1;
              state_nxt = S_CLR_RD;
            end
            OP_TOGGLE: begin
              if (in_node_ok) begin
                par_re    = 1'b1;
                par_raddr = in_if.node[AW-1:0];
                nw_re     = 1'b1;
                nw_raddr  = in_if.node[AW-1:0];
                build_nxt = 1'b0;
                state_nxt = S_T_WR;
              end
            end
            default: begin
              nw_re     = 1'b1;
              nw_raddr  = in_if.node[AW-1:0];
              state_nxt = S_Q_OUT;
            end
          endcase
        end
      end
      S_CLR_RD: begin
        nw_re     = 1'b1;
        nw_raddr  = idx_r;
        state_nxt = S_CLR_WR;
      end
      S_CLR_WR: begin
        // Zero the count; set the mark inside 1..last, keep it elsewhere.
        nw_we          = 1'b1;
        nw_waddr       = idx_r;
        nw_wdata.count = '0;
        nw_wdata.mark  = ((NODE_W'(idx_r) != '0) && (NODE_W'(idx_r) <= last_r)) ?
                         1'b1 : nw_rdata.mark;
        if (idx_r == AW'(DEPTH - 1)) begin
          idx_nxt = '0;
          if (last_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = NODE_W'(1);
            t_nxt     = NODE_W'(1);
            steps_nxt = '0;
            dec_nxt   = 1'b0;
            state_nxt = S_W_CHK;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_CLR_RD;
        end
      end
      S_W_CHK: begin
        // The write of the previous level landed last edge, so this read sees it.
        if (walk_go) begin
          par_re    = 1'b1;
          par_raddr = t_r[AW-1:0];
          nw_re     = 1'b1;
          nw_raddr  = t_r[AW-1:0];
          state_nxt = S_W_UP;
        end else if (build_r && (i_r != last_r)) begin
          i_nxt     = i_r + NODE_W'(1);
          t_nxt     = i_r + NODE_W'(1);
          steps_nxt = '0;
        end else begin
          build_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      S_W_UP: begin
        nw_we          = 1'b1;
        nw_waddr       = t_r[AW-1:0];
        nw_wdata.mark  = nw_rdata.mark;
        nw_wdata.count = nw_rdata.count + step_val;
        t_nxt          = par_rdata;
        steps_nxt      = steps_r + SW'(1);
        state_nxt      = S_W_CHK;
      end
      S_T_WR: begin
        // Flip the mark; node zero changes no count and ends the walk here.
        nw_we          = 1'b1;
        nw_waddr       = node_r[AW-1:0];
        nw_wdata.mark  = !nw_rdata.mark;
        nw_wdata.count = (node_r != '0) ? nw_rdata.count + first_step : nw_rdata.count;
        dec_nxt        = nw_rdata.mark;
        t_nxt          = (node_r != '0) ? par_rdata : '0;
        steps_nxt      = SW'(1);
        state_nxt      = S_W_CHK;
      end
      S_Q_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = node_ok ? nw_rdata.count : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      idx_r        <= '0;
      build_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      node_count_r <= NODE_W'(1);
      steps_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      build_r      <= build_nxt;
      out_valid_r  <= out_valid_nxt;
      node_count_r <= node_count_nxt;
      steps_r      <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    last_r      <= last_nxt;
    t_r         <= t_nxt;
    node_r      <= node_nxt;
    dec_r       <= dec_nxt;
    out_count_r <= out_count_nxt;
  end

  `ASSERT_IMPL(a_node_ram_rw_excl, nw_we, !nw_re, "node memory read and written in one cycle")
  `ASSERT_IMPL(a_steps_bound, 1'b1, 32'(steps_r) <= MAX_NODES, "walk exceeded its step bound")
  `ASSERT_IMPL(a_out_from_query, $rose(out_valid_r), $past(state_r == S_Q_OUT),
               "result raised outside a query")
  `ASSERT_IMPL(a_no_link_in_walk, (state_r == S_W_UP) || (state_r == S_W_CHK), !par_we,
               "parent memory written during a walk")

endmodule

// File: verif/tb.sv
// Testbench for the subtree count toggle tree unit: directed and random tree operations.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stt_pkg::*;

  localparam int MAX_NODES = 1024;
  localparam logic [2:0] REG_NODE_COUNT = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  subtree_count_toggle_tree_unit #(
    .MAX_NODES(MAX_NODES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Mirror of the tree: parent table, mark bits, subtree counts.
  // mark_known tracks which marks were ever written by a build, so the
  // stimulus never toggles a node whose mark is still undefined.
  logic [NODE_W-1:0] parent_tbl [MAX_NODES];
  logic              mark_tbl   [MAX_NODES];
  bit                mark_known [MAX_NODES];
  logic [CNT_W-1:0]  count_tbl  [MAX_NODES];
  int unsigned       node_limit;

  // Counts that outstanding queries are due to return, oldest first.
  logic [CNT_W-1:0]  count_due [$];
  logic [CNT_W-1:0]  due_count;

  int unsigned mismatch_count;
  // Rough cycle cost of the last operation handed over; sets the pause
  // before a register write so that a build or walk is surely finished.
  int unsigned last_cycles;
  // Set during a stretch where neither side idles.
  bit          steady;

  always #1 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Add or subtract one along the ancestor chain of start; return the levels walked.
  // The walk stops at parent 0 and after MAX_NODES steps, so cycles terminate.
  function automatic int unsigned walk_tally(int unsigned start, bit down);
    int unsigned at;
    int unsigned steps;
    at = start;
    steps = 0;
    while (at != 0 && at < MAX_NODES && steps < MAX_NODES) begin
      if (down) count_tbl[at] = count_tbl[at] - CNT_W'(1);
      else count_tbl[at] = count_tbl[at] + CNT_W'(1);
      at = 32'(parent_tbl[at]);
      steps++;
    end
    return steps;
  endfunction

  // Update the tree mirror for one accepted operation and queue any query answer.
  // The node field is 10 bits, so it never exceeds the table here.
  task automatic apply_to_tree(op_t op, logic [NODE_W-1:0] node,
                               logic [NODE_W-1:0] parent);
    int unsigned last;
    int unsigned cost;
    case (op)
      OP_LINK: begin
        parent_tbl[node] = parent;
        cost = 1;
      end
      OP_BUILD: begin
        last = (node_limit > MAX_NODES - 1) ? MAX_NODES - 1 : node_limit;
        for (int i = 1; i <= last; i++) begin
          mark_tbl[i] = 1'b1;
          mark_known[i] = 1'b1;
        end
        foreach (count_tbl[i]) count_tbl[i] = '0;
        cost = 2 * MAX_NODES;
        for (int i = 1; i <= last; i++) cost += 1 + 2 * walk_tally(i, 1'b0);
      end
      OP_TOGGLE: begin
        mark_tbl[node] = !mark_tbl[node];
        // A mark that just went low takes one away from the node and every ancestor.
        cost = 2 + 2 * walk_tally(32'(node), !mark_tbl[node]);
      end
      default: begin
        count_due.push_back(count_tbl[node]);
        cost = 2;
      end
    endcase
    last_cycles = cost;
  endtask

  // Offer one operation and hold it until the block takes it.
  // Valid stays high afterwards, so back-to-back items need no extra edge.
  task automatic send_op(op_t op, logic [NODE_W-1:0] node, logic [NODE_W-1:0] parent);
    if (!steady && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.node   <= node;
    in_ch.parent <= parent;
    do @(posedge clk); while (!in_ch.ready);
    apply_to_tree(op, node, parent);
  endtask

  // Drop valid and hold until every queued query answer has come back.
  task automatic await_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (count_due.size() != 0);
  endtask

  // Drain results, then let the last toggle or build finish its walks.
  task automatic settle();
    await_results();
    repeat (last_cycles + 32) @(posedge clk);
  endtask

  // Write node_count over the register port: setup cycle, then access cycle.
  task automatic set_node_count(int unsigned n);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= REG_NODE_COUNT;
    pwdata  <= n;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_limit = n;
  endtask

  // Check each result transaction against the oldest due count; stall at random.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (count_due.size() == 0) begin
        report_mismatch($sformatf("count %0d arrived with no query waiting", out_ch.count));
      end else begin
        due_count = count_due.pop_front();
        if (out_ch.count !== due_count)
          report_mismatch($sformatf("count %0d, expected %0d", out_ch.count, due_count));
      end
    end
    out_ch.ready <= steady || ($urandom_range(99) >= 30);
  end

  // Link a fresh tree over nodes 1..n, build it, then run a random mix of
  // toggles, queries, relinks and rebuilds. A rooted tree hangs every node
  // under node 1, so node 1 counts all of them. Small trees lean toward
  // long chains. The phase ends on a query so that draining means idle.
  task automatic run_forest(int unsigned n, bit rooted, int unsigned ops);
    int unsigned roll;
    int unsigned pick;
    int unsigned up;
    settle();
    set_node_count(n);
    for (int i = 1; i <= n; i++) begin
      if (rooted && i > 1) up = $urandom_range(i - 1, 1);
      else if (n <= 16 && $urandom_range(1) == 1) up = i - 1;
      else up = $urandom_range(i - 1, 0);
      send_op(OP_LINK, NODE_W'(i), NODE_W'(up));
    end
    send_op(OP_BUILD, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
    repeat (ops) begin
      roll = $urandom_range(99);
      // Now and then hold the sender until every answer is back.
      if (roll < 2) await_results();
      if (roll < 40) begin
        // Toggle only nodes whose mark a build has set.
        pick = $urandom_range(1023, 1);
        if (!($urandom_range(9) == 0 && mark_known[pick])) pick = $urandom_range(n, 1);
        send_op(OP_TOGGLE, NODE_W'(pick), NODE_W'($urandom_range(1023)));
      end else if (roll < 78) begin
        pick = ($urandom_range(6) == 0) ? $urandom_range(1023) : $urandom_range(n, 1);
        send_op(OP_QUERY, NODE_W'(pick), NODE_W'($urandom_range(1023)));
      end else if (roll < 95) begin
        // Relink below the node itself, which keeps the table free of cycles.
        pick = ($urandom_range(2) == 0) ? $urandom_range(1023, 1) : $urandom_range(n, 1);
        send_op(OP_LINK, NODE_W'(pick), NODE_W'($urandom_range(pick - 1, 0)));
      end else begin
        send_op(OP_BUILD, NODE_W'($urandom_range(1023)), NODE_W'($urandom_range(1023)));
      end
    end
    send_op(OP_QUERY, NODE_W'($urandom_range(n, 1)), NODE_W'($urandom_range(1023)));
  endtask

  // Short chain 1 <- 2 <- 3: extreme nodes, node zero, counts up and down,
  // relinking between toggles and a subtract from zero that wraps.
  task automatic test_directed_edges();
    settle();
    set_node_count(3);
    send_op(OP_LINK, 1, 0);
    send_op(OP_LINK, 2, 1);
    send_op(OP_LINK, 3, 2);
    send_op(OP_LINK, 0, 1023);
    send_op(OP_LINK, 1023, 3);
    send_op(OP_BUILD, 1023, 1023);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_QUERY, 3, 0);
    send_op(OP_QUERY, 0, 0);
    send_op(OP_QUERY, 1023, 1023);
    send_op(OP_TOGGLE, 3, 0);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_LINK, 3, 0);
    send_op(OP_TOGGLE, 3, 0);
    send_op(OP_LINK, 3, 2);
    send_op(OP_TOGGLE, 3, 0);
    send_op(OP_QUERY, 2, 0);
    send_op(OP_TOGGLE, 1, 0);
    send_op(OP_TOGGLE, 2, 0);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_QUERY, 2, 0);
  endtask

  // Two nodes pointing at each other: build and toggle walks must stop
  // after MAX_NODES steps. Break the loop at the end for later phases.
  task automatic test_ancestor_cycle();
    settle();
    set_node_count(2);
    send_op(OP_LINK, 1, 2);
    send_op(OP_LINK, 2, 1);
    send_op(OP_BUILD, 0, 0);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_QUERY, 2, 0);
    send_op(OP_TOGGLE, 1, 0);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_QUERY, 2, 0);
    send_op(OP_LINK, 1, 0);
    send_op(OP_TOGGLE, 2, 0);
    send_op(OP_QUERY, 1, 0);
    send_op(OP_QUERY, 2, 0);
  endtask

  // Largest node_count with every node under node 1: root count hits 1023
  // and wraps when a further mark is added.
  task automatic test_full_tree();
    run_forest(1023, 1'b1, 150);
  endtask

  // Several small trees, node_count of 1 among them; one phase without idling.
  task automatic test_random_forests();
    for (int k = 0; k < 6; k++) begin
      steady = (k == 2);
      run_forest((k == 0) ? 1 : $urandom_range(48, 2), $urandom_range(1), 150);
    end
    steady = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_LINK;
    in_ch.node     = '0;
    in_ch.parent   = '0;
    mismatch_count = 0;
    last_cycles    = 0;
    steady         = 1'b0;
    node_limit     = 1;
    foreach (parent_tbl[i]) begin
      parent_tbl[i] = '0;
      mark_tbl[i]   = 1'b0;
      mark_known[i] = 1'b0;
      count_tbl[i]  = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_ancestor_cycle();
    test_full_tree();
    test_random_forests();

    settle();
    if (mismatch_count == 0) begin
      $display("subtree_count_toggle_tree_unit verification clean");
    end else begin
      $display("subtree_count_toggle_tree_unit verification failed");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("subtree_count_toggle_tree_unit verification failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/stt_pkg.sv
design/stt_in_if.sv
design/stt_out_if.sv
design/stt_ram.sv
design/subtree_count_toggle_tree_unit.sv
verif/tb.sv
